[src/gaussian_frequency_mask_generator_defines.svh]
// Assertion macros shared by the mask generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GAUSSIAN_FREQUENCY_MASK_GENERATOR_DEFINES_SVH
`define GAUSSIAN_FREQUENCY_MASK_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define GFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define GFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/gfm_pkg.sv]
// Package for the gaussian frequency mask generator: codes, widths, tag type.
// No dependencies; imported by every module of the block.
package gfm_pkg;

  // Filter mode codes.
  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_BAND = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_CUTOFF_RADIUS = 3'd3;
  localparam logic [2:0] REG_BAND_WIDTH    = 3'd4;

  // How the final Q30 value of an item is chosen.
  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  localparam int OFF_W        = 20;
  localparam int N_W          = 60;
  localparam int D_W          = 55;
  localparam int R_W          = 60;
  localparam int DS_W         = 59;
  localparam int T_W          = 34;
  localparam int X_W          = 30;
  localparam int P_W          = 31;
  localparam int NSH_W        = 5;
  localparam int DIV_STEPS    = 34;
  localparam int LN_STEPS     = 5;
  localparam int HORNER_TERMS = 12;

  localparam logic [P_W-1:0] Q_ONE   = P_W'(1) << 30;
  localparam logic [X_W-1:0] LN2_Q30 = 30'd744261118;

  // Side information that travels with each request down the chain.
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic             high;
    logic [OFF_W-1:0] offset;
  } tag_t;

endpackage

[src/gaussian_frequency_mask_generator.sv]
// Gaussian frequency mask generator, top level: registers, cell chains, output.
// Depends on gfm_pkg, the defines header, gfm_prep and the three cell modules.
//
// Usage: raise start with col and row of a half-spectrum bin; the request is
// taken at a rising edge where start is high and busy is low. busy is high only
// during reset, so a new request may be taken in every cycle. Each request gives
// one result, marked by done for one cycle, with gain (unsigned Q0.GAIN_BITS)
// and offset = row*(image_width/2+1)+col. Results come out in request order.
// The path has 6 front-end stages, 34 division cells (one quotient bit each), 5
// range-reduction cells, 12 Horner cells of 3 stages each and the output register.
// Throughput is one result per cycle, set by the chain of cells, each handing its
// data to the next on every clock. Registers are written through cfg_we, cfg_index
// and cfg_data, which the user must do only while no request is in flight; the
// block does not enforce it. An index beyond the five registers is ignored.
// Synchronous reset restores the register defaults and drops every request in
// flight. The receiver has no way to stall; results must be taken when shown.
`include "gaussian_frequency_mask_generator_defines.svh"

module gaussian_frequency_mask_generator import gfm_pkg::*; #(
  parameter int GAIN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [9:0]           col,
  input  logic [9:0]           row,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 done,
  output logic [GAIN_BITS-1:0] gain,
  output logic [OFF_W-1:0]     offset
);

  localparam int LATENCY = 6 + DIV_STEPS + LN_STEPS + 3 * HORNER_TERMS + 1;
  localparam int SHR     = (30 - GAIN_BITS) > 0 ? (30 - GAIN_BITS) : 0;
  localparam int SHL     = (GAIN_BITS - 30) > 0 ? (GAIN_BITS - 30) : 0;
  localparam int GW      = P_W + SHL + 1;
  localparam logic [GW-1:0] ROUND =
    (SHR > 0) ? (GW'(1) << ((SHR > 0) ? (SHR - 1) : 0)) : '0;
  localparam logic [GAIN_BITS-1:0] GMAX = '1;

  mode_t       filter_mode;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [10:0] cutoff_radius;
  logic [15:0] band_width;

  logic accept;

  tag_t            div_tag [DIV_STEPS+1];
  logic [R_W-1:0]  div_rem [DIV_STEPS+1];
  logic [DS_W-1:0] div_dsh [DIV_STEPS+1];
  logic [T_W-1:0]  div_quo [DIV_STEPS+1];

  tag_t             lnr_tag [LN_STEPS+1];
  logic [T_W-1:0]   lnr_r   [LN_STEPS+1];
  logic [NSH_W-1:0] lnr_n   [LN_STEPS+1];

  tag_t             hrn_tag [HORNER_TERMS+1];
  logic [X_W-1:0]   hrn_r   [HORNER_TERMS+1];
  logic [P_W-1:0]   hrn_p   [HORNER_TERMS+1];
  logic [NSH_W-1:0] hrn_n   [HORNER_TERMS+1];

  logic [P_W-1:0]       e_val;
  logic [P_W-1:0]       sel_val;
  logic [P_W-1:0]       fin_val;
  logic [GW-1:0]        wide;
  logic [GW-1:0]        g_sh;
  logic [GAIN_BITS-1:0] gain_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= MODE_LOW;
      image_width   <= 11'd256;
      image_height  <= 11'd256;
      cutoff_radius <= 11'd16;
      band_width    <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE:   filter_mode   <= mode_t'(cfg_data[1:0]);
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[10:0];
        REG_CUTOFF_RADIUS: cutoff_radius <= cfg_data[10:0];
        REG_BAND_WIDTH:    band_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: distance, offset and the exponent as a ratio.
  gfm_prep u_prep (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .col           (col),
    .row           (row),
    .filter_mode   (filter_mode),
    .image_width   (image_width),
    .image_height  (image_height),
    .cutoff_radius (cutoff_radius),
    .band_width    (band_width),
    .tag_o         (div_tag[0]),
    .rem_o         (div_rem[0]),
    .dsh_o         (div_dsh[0])
  );

  assign div_quo[0] = '0;

  // Division chain: exponent t in Q30.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    gfm_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .tag_i (div_tag[i]),
      .rem_i (div_rem[i]),
      .dsh_i (div_dsh[i]),
      .quo_i (div_quo[i]),
      .tag_o (div_tag[i+1]),
      .rem_o (div_rem[i+1]),
      .dsh_o (div_dsh[i+1]),
      .quo_o (div_quo[i+1])
    );
  end

  assign lnr_tag[0] = div_tag[DIV_STEPS];
  assign lnr_r[0]   = div_quo[DIV_STEPS];
  assign lnr_n[0]   = '0;

  // Range reduction chain, most significant bit of n first.
  for (genvar i = 0; i < LN_STEPS; i++) begin : g_lnr
    gfm_lnr_cell #(.SHIFT(LN_STEPS - 1 - i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .tag_i (lnr_tag[i]),
      .r_i   (lnr_r[i]),
      .n_i   (lnr_n[i]),
      .tag_o (lnr_tag[i+1]),
      .r_o   (lnr_r[i+1]),
      .n_o   (lnr_n[i+1])
    );
  end

  assign hrn_tag[0] = lnr_tag[LN_STEPS];
  assign hrn_r[0]   = lnr_r[LN_STEPS][X_W-1:0];
  assign hrn_p[0]   = Q_ONE;
  assign hrn_n[0]   = lnr_n[LN_STEPS];

  // Horner chain, highest term first.
  for (genvar i = 0; i < HORNER_TERMS; i++) begin : g_hrn
    gfm_horner_cell #(.K(HORNER_TERMS - i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .tag_i (hrn_tag[i]),
      .r_i   (hrn_r[i]),
      .p_i   (hrn_p[i]),
      .n_i   (hrn_n[i]),
      .tag_o (hrn_tag[i+1]),
      .r_o   (hrn_r[i+1]),
      .p_o   (hrn_p[i+1]),
      .n_o   (hrn_n[i+1])
    );
  end

  // Scale by 2^-n, apply special cases and the highpass complement.
  assign e_val = hrn_p[HORNER_TERMS] >> hrn_n[HORNER_TERMS];

  always_comb begin
    case (hrn_tag[HORNER_TERMS].kind)
      KIND_ONE:  sel_val = Q_ONE;
      KIND_ZERO: sel_val = '0;
      default:   sel_val = e_val;
    endcase
  end

  assign fin_val = hrn_tag[HORNER_TERMS].high ? (Q_ONE - sel_val) : sel_val;

  // Round half up to the gain width and saturate.
  assign wide      = (GW'(fin_val) << SHL) + ROUND;
  assign g_sh      = wide >> SHR;
  assign gain_next = (g_sh > GW'(GMAX)) ? GMAX : g_sh[GAIN_BITS-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    done   <= hrn_tag[HORNER_TERMS].valid && !rst;
    gain   <= gain_next;
    offset <= hrn_tag[HORNER_TERMS].offset;
  end

  `GFM_ASSERT_IMP(a_done_latency, done, $past(accept, LATENCY), "result without a request")
  `GFM_ASSERT_IMP(a_div_bound, div_tag[0].valid && div_tag[0].kind == KIND_CALC, div_rem[0] < R_W'(div_dsh[0]), "exponent ratio not below sixteen")
  `GFM_ASSERT_IMP(a_lnr_bound, lnr_tag[LN_STEPS].valid && lnr_tag[LN_STEPS].kind == KIND_CALC, lnr_r[LN_STEPS] < T_W'(LN2_Q30), "range reduction left r above ln2")
  `GFM_ASSERT_IMP(a_off_mode, done && filter_mode == MODE_OFF, gain == '0, "unused mode gave a nonzero gain")
  `GFM_ASSERT_NXT(a_final_handoff, hrn_tag[HORNER_TERMS].valid, done, "finished request not shown")

endmodule

[src/gfm_prep.sv]
// Front end of the mask generator: distance, offset and exponent ratio.
// Depends on gfm_pkg; feeds the first divider cell.
module gfm_prep import gfm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [9:0]      col,
  input  logic [9:0]      row,
  input  mode_t           filter_mode,
  input  logic [10:0]     image_width,
  input  logic [10:0]     image_height,
  input  logic [10:0]     cutoff_radius,
  input  logic [15:0]     band_width,
  output tag_t            tag_o,
  output logic [R_W-1:0]  rem_o,
  output logic [DS_W-1:0] dsh_o
);

  logic [9:0]  hw;
  logic [9:0]  hh;
  logic [10:0] hw1;

  logic                    v1;
  logic [9:0]              col1;
  logic signed [11:0]      dx1;
  logic signed [11:0]      dy1;
  logic [OFF_W-1:0]        offp1;

  logic                    v2;
  logic [OFF_W-1:0]        off2;
  logic [20:0]             dxx2;
  logic [20:0]             dyy2;
  logic [21:0]             c2_2;
  logic [31:0]             bw2_2;
  logic signed [23:0]      dxsq;
  logic signed [23:0]      dysq;

  logic                    v3;
  logic [OFF_W-1:0]        off3;
  logic [21:0]             d2_3;
  logic [21:0]             c2_3;
  logic [31:0]             bw2_3;

  logic                    v4;
  logic [OFF_W-1:0]        off4;
  logic [21:0]             d2_4;
  logic [21:0]             c2_4;
  logic [21:0]             diff4;
  logic [31:0]             bw2_4;

  logic                    v5;
  logic [OFF_W-1:0]        off5;
  logic [21:0]             d2_5;
  logic [21:0]             c2_5;
  logic [43:0]             sq5;
  logic [53:0]             dbw5;

  kind_t                   kind6;
  logic [N_W-1:0]          num6;
  logic [D_W-1:0]          den6;

  assign hw  = image_width[10:1];
  assign hh  = image_height[10:1];
  assign hw1 = {1'b0, hw} + 11'd1;

  // Stage 1: signed distances from the spectrum center and the row offset product.
  always_ff @(posedge clk) begin
    v1    <= accept && !rst;
    col1  <= col;
    dx1   <= $signed({2'b00, col}) + 12'sd1 - $signed({2'b00, hw});
    dy1   <= $signed({2'b00, row}) + 12'sd1 - $signed({2'b00, hh});
    offp1 <= OFF_W'(row) * OFF_W'(hw1);
  end

  assign dxsq = dx1 * dx1;
  assign dysq = dy1 * dy1;

  // Stage 2: squares of the distances, cutoff and band width.
  always_ff @(posedge clk) begin
    v2    <= v1 && !rst;
    off2  <= offp1 + OFF_W'(col1);
    dxx2  <= dxsq[20:0];
    dyy2  <= dysq[20:0];
    c2_2  <= 22'(cutoff_radius) * 22'(cutoff_radius);
    bw2_2 <= 32'(band_width) * 32'(band_width);
  end

  // Stage 3: squared radius.
  always_ff @(posedge clk) begin
    v3    <= v2 && !rst;
    off3  <= off2;
    d2_3  <= 22'(dxx2) + 22'(dyy2);
    c2_3  <= c2_2;
    bw2_3 <= bw2_2;
  end

  // Stage 4: distance of the squared radius from the squared cutoff.
  always_ff @(posedge clk) begin
    v4    <= v3 && !rst;
    off4  <= off3;
    d2_4  <= d2_3;
    c2_4  <= c2_3;
    diff4 <= (d2_3 >= c2_3) ? (d2_3 - c2_3) : (c2_3 - d2_3);
    bw2_4 <= bw2_3;
  end

  // Stage 5: bandpass numerator and denominator products.
  always_ff @(posedge clk) begin
    v5   <= v4 && !rst;
    off5 <= off4;
    d2_5 <= d2_4;
    c2_5 <= c2_4;
    sq5  <= 44'(diff4) * 44'(diff4);
    dbw5 <= 54'(d2_4) * 54'(bw2_4);
  end

  // Pick the exponent ratio per mode and settle the special cases.
  always_comb begin
    kind6 = KIND_CALC;
    num6  = '0;
    den6  = '0;
    case (filter_mode)
      MODE_LOW, MODE_HIGH: begin
        num6 = N_W'(d2_5);
        den6 = D_W'({c2_5, 1'b0});
        if (d2_5 == '0) begin
          kind6 = KIND_ONE;
        end else if (c2_5 == '0) begin
          kind6 = KIND_ZERO;
        end else if ({5'b0, d2_5} >= {c2_5, 5'b0}) begin
          kind6 = KIND_ZERO;
        end
      end
      MODE_BAND: begin
        num6 = {sq5, 16'b0};
        den6 = {dbw5, 1'b0};
        if (d2_5 == '0) begin
          kind6 = KIND_ZERO;
        end else if (sq5 == '0) begin
          kind6 = KIND_ONE;
        end else if (dbw5 == '0) begin
          kind6 = KIND_ZERO;
        end else if ({sq5, 12'b0} >= {1'b0, dbw5, 1'b0}) begin
          kind6 = KIND_ZERO;
        end
      end
      default: kind6 = KIND_ZERO;
    endcase
  end

  // Stage 6: hand the ratio to the divider with the divisor pre-shifted by four.
  always_ff @(posedge clk) begin
    tag_o.valid  <= v5 && !rst;
    tag_o.kind   <= kind6;
    tag_o.high   <= (filter_mode == MODE_HIGH);
    tag_o.offset <= off5;
    rem_o        <= num6;
    dsh_o        <= {den6, 4'b0};
  end

endmodule

[src/gfm_div_cell.sv]
// One restoring step of the Q30 long division: one quotient bit per cell.
// Depends on gfm_pkg; chained in the top level.
module gfm_div_cell import gfm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  tag_t            tag_i,
  input  logic [R_W-1:0]  rem_i,
  input  logic [DS_W-1:0] dsh_i,
  input  logic [T_W-1:0]  quo_i,
  output tag_t            tag_o,
  output logic [R_W-1:0]  rem_o,
  output logic [DS_W-1:0] dsh_o,
  output logic [T_W-1:0]  quo_o
);

  logic [R_W-1:0] rem_sh;
  logic           ge;

  // Shift the partial remainder and try the divisor.
  assign rem_sh = {rem_i[R_W-2:0], 1'b0};
  assign ge     = (rem_sh >= R_W'(dsh_i));

  always_ff @(posedge clk) begin
    tag_o <= rst ? '0 : tag_i;
    rem_o <= ge ? (rem_sh - R_W'(dsh_i)) : rem_sh;
    dsh_o <= dsh_i;
    quo_o <= {quo_i[T_W-2:0], ge};
  end

endmodule

[src/gfm_lnr_cell.sv]
// One step of the range reduction t = n*ln2 + r: one bit of n per cell.
// Depends on gfm_pkg; chained in the top level.
module gfm_lnr_cell import gfm_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tag_t             tag_i,
  input  logic [T_W-1:0]   r_i,
  input  logic [NSH_W-1:0] n_i,
  output tag_t             tag_o,
  output logic [T_W-1:0]   r_o,
  output logic [NSH_W-1:0] n_o
);

  localparam logic [T_W-1:0] STEP = T_W'(LN2_Q30) << SHIFT;

  logic ge;

  assign ge = (r_i >= STEP);

  // Subtract ln2 times this bit's weight when it fits.
  always_ff @(posedge clk) begin
    tag_o <= rst ? '0 : tag_i;
    r_o   <= ge ? (r_i - STEP) : r_i;
    n_o   <= n_i | (NSH_W'(ge) << SHIFT);
  end

endmodule

[src/gfm_horner_cell.sv]
// One Horner term of exp(-r): p = 1 - ((r*p) >> 30) / K over three stages.
// Depends on gfm_pkg; chained in the top level.
module gfm_horner_cell import gfm_pkg::*; #(
  parameter int K = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  tag_t             tag_i,
  input  logic [X_W-1:0]   r_i,
  input  logic [P_W-1:0]   p_i,
  input  logic [NSH_W-1:0] n_i,
  output tag_t             tag_o,
  output logic [X_W-1:0]   r_o,
  output logic [P_W-1:0]   p_o,
  output logic [NSH_W-1:0] n_o
);

  localparam logic [P_W-1:0] RECIP = P_W'((64'd1 << 30) / K);

  logic [60:0]      prod;
  tag_t             tag_a;
  logic [X_W-1:0]   x_a;
  logic [X_W-1:0]   r_a;
  logic [NSH_W-1:0] n_a;

  logic [60:0]      y;
  tag_t             tag_b;
  logic [60:0]      y_b;
  logic [X_W-1:0]   x_b;
  logic [X_W-1:0]   r_b;
  logic [NSH_W-1:0] n_b;

  logic [X_W-1:0]   q0;
  logic [X_W-1:0]   rem_c;
  logic [X_W-1:0]   q;

  // Stage a: product of r and the running term, back to Q30.
  assign prod = 61'(r_i) * 61'(p_i);

  always_ff @(posedge clk) begin
    tag_a <= rst ? '0 : tag_i;
    x_a   <= prod[59:30];
    r_a   <= r_i;
    n_a   <= n_i;
  end

  // Stage b: estimate of x / K through the reciprocal; it may fall short by one.
  assign y = 61'(x_a) * 61'(RECIP);

  always_ff @(posedge clk) begin
    tag_b <= rst ? '0 : tag_a;
    y_b   <= y;
    x_b   <= x_a;
    r_b   <= r_a;
    n_b   <= n_a;
  end

  // Stage c: correct the estimate and form the next term.
  assign q0    = y_b[59:30];
  assign rem_c = x_b - X_W'(q0 * X_W'(K));
  assign q     = (rem_c >= X_W'(K)) ? (q0 + X_W'(1)) : q0;

  always_ff @(posedge clk) begin
    tag_o <= rst ? '0 : tag_b;
    r_o   <= r_b;
    p_o   <= Q_ONE - P_W'(q);
    n_o   <= n_b;
  end

endmodule
